// ===== sv/button_mode_led_pattern_controller_core_defines.svh =====
// Assertion macros used by the checker file of the LED mode sequencer
`ifndef BUTTON_MODE_LED_PATTERN_CONTROLLER_CORE_DEFINES_SVH
`define BUTTON_MODE_LED_PATTERN_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BMLPC_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BMLPC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bmlpc_pkg.sv =====
// Types, codes and constants of the LED mode sequencer
package bmlpc_pkg;

	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int PHASE_W    = 5;
	localparam int SOS_PHASES = 18;

	// mode codes
	localparam logic [1:0] MD_OFF   = 2'd0;
	localparam logic [1:0] MD_ON    = 2'd1;
	localparam logic [1:0] MD_FLASH = 2'd2;
	localparam logic [1:0] MD_SOS   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OFF  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON   = 2'd3;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] FLASH_OFF_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] FLASH_ON_RST   = 16'd100;

	localparam logic [CFG_W-1:0] SOS_DOT  = 16'd200;
	localparam logic [CFG_W-1:0] SOS_DASH = 16'd600;
	localparam logic [CFG_W-1:0] SOS_GAP  = 16'd1000;

	// mode decision handed from the button logic to the pattern logic
	typedef struct packed {
		logic [1:0] mode;
		logic       changed;
	} mode_evt_t;

	// phase length of the SOS pattern; even phases lit, odd phases dark
	function automatic logic [CFG_W-1:0] sos_len(input logic [PHASE_W-1:0] ph);
		logic [CFG_W-1:0] len;
		case (ph)
			5'd5, 5'd6, 5'd8, 5'd10, 5'd11: len = SOS_DASH;
			5'd17:                          len = SOS_GAP;
			default:                        len = SOS_DOT;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/bmlpc_button.sv =====
// Edge debounce, press timing and mode stepping for one tick
module bmlpc_button import bmlpc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                  level,
	input  logic                  prior,
	input  logic [TIMER_BITS-1:0] since_edge,
	input  logic [TIMER_BITS-1:0] press_timer,
	input  logic [1:0]            cur_mode,
	input  logic [CFG_W-1:0]      debounce_ticks,
	input  logic [CFG_W-1:0]      long_press_ticks,
	output logic [TIMER_BITS-1:0] since_edge_nx,
	output logic [TIMER_BITS-1:0] press_timer_nx,
	output mode_evt_t             evt
);

	localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [TIMER_BITS-1:0] since_inc;
	logic [TIMER_BITS-1:0] press_inc;
	logic [1:0]            step_mode;
	logic [1:0]            new_mode;
	logic                  edge_ok;
	logic                  long_press;

	// saturating tick counters
	assign since_inc = (&since_edge)  ? since_edge  : since_edge + 1'b1;
	assign press_inc = (&press_timer) ? press_timer : press_timer + 1'b1;

	assign edge_ok    = (level != prior) && (CW'(since_inc) >= CW'(debounce_ticks));
	assign long_press = CW'(press_inc) >= CW'(long_press_ticks);

	// short press steps OFF -> ON -> FLASH -> SOS -> ON
	always_comb begin
		case (cur_mode)
			MD_OFF:   step_mode = MD_ON;
			MD_ON:    step_mode = MD_FLASH;
			MD_FLASH: step_mode = MD_SOS;
			default:  step_mode = MD_ON;
		endcase
	end

	assign new_mode = long_press ? MD_OFF : step_mode;

	// counted edge: rising starts press timing, falling decides the mode
	always_comb begin
		since_edge_nx = since_inc;
		press_timer_nx = press_inc;
		evt.mode = cur_mode;
		evt.changed = 1'b0;
		if (edge_ok) begin
			since_edge_nx = '0;
			if (level) begin
				press_timer_nx = '0;
			end else if (new_mode != cur_mode) begin
				evt.mode = new_mode;
				evt.changed = 1'b1;
			end
		end
	end

endmodule

// ===== sv/bmlpc_pattern.sv =====
// LED pattern generator: off, on, flash and SOS phases
module bmlpc_pattern import bmlpc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  mode_evt_t             evt,
	input  logic [PHASE_W-1:0]    phase,
	input  logic [TIMER_BITS-1:0] phase_timer,
	input  logic [CFG_W-1:0]      flash_off_ticks,
	input  logic [CFG_W-1:0]      flash_on_ticks,
	output logic                  led,
	output logic [PHASE_W-1:0]    phase_nx,
	output logic [TIMER_BITS-1:0] phase_timer_nx
);

	localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [PHASE_W-1:0]    ph_start;
	logic [TIMER_BITS-1:0] tm_start;
	logic [PHASE_W-1:0]    ph;
	logic [TIMER_BITS-1:0] tm_inc;
	logic [CFG_W-1:0]      len;
	logic                  done;

	// a mode change restarts the pattern at phase 0 on this tick
	assign ph_start = evt.changed ? '0 : phase;
	assign tm_start = evt.changed ? '0 : phase_timer;
	assign tm_inc   = (&tm_start) ? tm_start : tm_start + 1'b1;

	// phase in range and its length
	always_comb begin
		ph = '0;
		len = '0;
		if (evt.mode == MD_FLASH) begin
			ph = (ph_start > PHASE_W'(1)) ? '0 : ph_start;
			len = ph[0] ? flash_on_ticks : flash_off_ticks;
		end else if (evt.mode == MD_SOS) begin
			ph = (ph_start >= PHASE_W'(SOS_PHASES)) ? '0 : ph_start;
			len = sos_len(ph);
		end
	end

	assign done = CW'(tm_inc) >= CW'(len);

	// LED drive and phase advance
	always_comb begin
		led = 1'b0;
		phase_nx = '0;
		phase_timer_nx = '0;
		case (evt.mode)
			MD_FLASH: begin
				led = ph[0];
				phase_nx = done ? {ph[PHASE_W-1:1], ~ph[0]} : ph;
				phase_timer_nx = done ? '0 : tm_inc;
			end
			MD_SOS: begin
				led = ~ph[0];
				if (done) begin
					phase_nx = (ph == PHASE_W'(SOS_PHASES - 1)) ? '0 : ph + 1'b1;
				end else begin
					phase_nx = ph;
				end
				phase_timer_nx = done ? '0 : tm_inc;
			end
			MD_ON: begin
				led = 1'b1;
			end
			default: begin
				led = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/button_mode_led_pattern_controller_core.sv =====
// Button LED mode sequencer: one request per millisecond tick.
// Input channel: in_valid / in_stall with button_level, the raw button sample.
// Output channel: out_valid / out_stall with led, mode and mode_changed,
// exactly one result request for every accepted input request.
// Configuration: cfg_we, cfg_index, cfg_data write the debounce, long press
// and flash phase lengths; write them only while no tick is in flight.
// Each accepted tick passes the input register, then the result register,
// with the state update between them.
// Throughput: one tick per cycle while no stalled result holds the pipe.
// When the receiver stalls a waiting result, the whole two-register pipe
// holds and in_stall rises; it falls in the cycle the result is taken.
// Reset clears the pipe valid bits, all timers, the pattern phase and sets
// the mode to off; the configuration registers return to their defaults.
module button_mode_led_pattern_controller_core import bmlpc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 button_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 led,
	output logic [1:0]           mode,
	output logic                 mode_changed,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic                  adv;
	logic                  valid_s1;
	logic                  level_s1;
	logic                  valid_s2;
	logic                  led_s2;
	logic [1:0]            mode_s2;
	logic                  changed_s2;

	logic [CFG_W-1:0]      debounce_q;
	logic [CFG_W-1:0]      long_press_q;
	logic [CFG_W-1:0]      flash_off_q;
	logic [CFG_W-1:0]      flash_on_q;

	logic                  prior_q;
	logic [TIMER_BITS-1:0] since_edge_q;
	logic [TIMER_BITS-1:0] press_timer_q;
	logic [1:0]            mode_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [TIMER_BITS-1:0] phase_timer_q;

	logic [TIMER_BITS-1:0] since_edge_nx;
	logic [TIMER_BITS-1:0] press_timer_nx;
	logic [PHASE_W-1:0]    phase_nx;
	logic [TIMER_BITS-1:0] phase_timer_nx;
	logic                  led_nx;
	mode_evt_t             evt;

	// pipe moves unless a result is waiting and stalled
	assign adv      = !(valid_s2 && out_stall);
	assign in_stall = !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			flash_off_q <= FLASH_OFF_RST;
			flash_on_q <= FLASH_ON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:   debounce_q <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				CFG_FLASH_OFF:  flash_off_q <= cfg_data;
				CFG_FLASH_ON:   flash_on_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			level_s1 <= button_level;
		end
	end

	bmlpc_button #(
		.TIMER_BITS (TIMER_BITS)
	) u_button (
		.level            (level_s1),
		.prior            (prior_q),
		.since_edge       (since_edge_q),
		.press_timer      (press_timer_q),
		.cur_mode         (mode_q),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.since_edge_nx    (since_edge_nx),
		.press_timer_nx   (press_timer_nx),
		.evt              (evt)
	);

	bmlpc_pattern #(
		.TIMER_BITS (TIMER_BITS)
	) u_pattern (
		.evt             (evt),
		.phase           (phase_q),
		.phase_timer     (phase_timer_q),
		.flash_off_ticks (flash_off_q),
		.flash_on_ticks  (flash_on_q),
		.led             (led_nx),
		.phase_nx        (phase_nx),
		.phase_timer_nx  (phase_timer_nx)
	);

	// sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= 1'b0;
			since_edge_q <= '0;
			press_timer_q <= '0;
			mode_q <= MD_OFF;
			phase_q <= '0;
			phase_timer_q <= '0;
		end else if (adv && valid_s1) begin
			prior_q <= level_s1;
			since_edge_q <= since_edge_nx;
			press_timer_q <= press_timer_nx;
			mode_q <= evt.mode;
			phase_q <= phase_nx;
			phase_timer_q <= phase_timer_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			led_s2 <= led_nx;
			mode_s2 <= evt.mode;
			changed_s2 <= evt.changed;
		end
	end

	assign out_valid    = valid_s2;
	assign led          = led_s2;
	assign mode         = mode_s2;
	assign mode_changed = changed_s2;

endmodule

// ===== sv/bmlpc_checker.sv =====
// Port-level checks of the LED mode sequencer, bound to the top level
`include "button_mode_led_pattern_controller_core_defines.svh"

module bmlpc_checker import bmlpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       led,
	input logic [1:0] mode,
	input logic       mode_changed
);

	// a stalled result request keeps its payload
	`BMLPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(led) && $stable(mode) && $stable(mode_changed), "stalled result changed")

	// off mode keeps the LED dark
	`BMLPC_ASSERT_NOW(a_off_dark, clk, arst_n, out_valid && (mode == MD_OFF), !led, "LED lit in off mode")

	// on mode keeps the LED lit
	`BMLPC_ASSERT_NOW(a_on_lit, clk, arst_n, out_valid && (mode == MD_ON), led, "LED dark in on mode")

	// flash restarts in its dark phase, SOS in its first lit dot
	`BMLPC_ASSERT_NOW(a_restart, clk, arst_n, out_valid && mode_changed && ((mode == MD_FLASH) || (mode == MD_SOS)), led == (mode == MD_SOS), "pattern did not restart at phase 0")

endmodule

bind button_mode_led_pattern_controller_core bmlpc_checker u_bmlpc_checker (.*);

// ===== bench/button_mode_led_pattern_controller_core_tb.sv =====
// Testbench of the button LED mode sequencer: predicted and checked ticks, register sweeps, soak
module button_mode_led_pattern_controller_core_tb;
	import bmlpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB_TIMER_BITS = 16;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int RAND_PHASES   = 12;
	localparam int TICKS_PER_PH  = 70;

	typedef struct packed {
		logic       led;
		logic [1:0] mode;
		logic       changed;
	} tick_result_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic                 level;
		logic                 known;
		tick_result_t         want;
	} dir_row_t;

	localparam tick_result_t NO_CHECK = '0;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 button_level = 1'b0;
	logic                 out_stall    = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_DEBOUNCE;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 led;
	logic [1:0]           mode;
	logic                 mode_changed;

	button_mode_led_pattern_controller_core #(.TIMER_BITS(TB_TIMER_BITS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led          (led),
		.mode         (mode),
		.mode_changed (mode_changed),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state and shadow registers
	logic                     lvl_prev  = 1'b0;
	logic [TB_TIMER_BITS-1:0] edge_age  = '0;
	logic [TB_TIMER_BITS-1:0] press_age = '0;
	logic [TB_TIMER_BITS-1:0] phase_age = '0;
	logic [1:0]               cur_mode  = MD_OFF;
	logic [PHASE_W-1:0]       morse_phase = '0;
	logic [CFG_W-1:0]         db_cfg    = DEBOUNCE_RST;
	logic [CFG_W-1:0]         lp_cfg    = LONG_PRESS_RST;
	logic [CFG_W-1:0]         foff_cfg  = FLASH_OFF_RST;
	logic [CFG_W-1:0]         fon_cfg   = FLASH_ON_RST;

	tick_result_t expected_ticks [$];
	tick_result_t head;
	int           ticks_sent     = 0;
	int           ticks_checked  = 0;
	int           mismatches     = 0;
	int           cycle_count    = 0;
	int           backpressure_left = 0;
	bit           backpressure_done = 1'b0;
	bit           steady         = 1'b0;

	// directed table: power-up, debounce window, full mode walk, long press, same mode
	dir_row_t dir_rows [25] = '{
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b0, MD_OFF,   1'b0}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b1, '{1'b0, MD_OFF,   1'b0}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b0, MD_OFF,   1'b0}},
		'{ROW_WRITE, CFG_DEBOUNCE,   16'd0,     1'b0, 1'b0, NO_CHECK},
		'{ROW_WRITE, CFG_LONG_PRESS, 16'd3,     1'b0, 1'b0, NO_CHECK},
		'{ROW_WRITE, CFG_FLASH_OFF,  16'd0,     1'b0, 1'b0, NO_CHECK},
		'{ROW_WRITE, CFG_FLASH_ON,   16'hFFFF,  1'b0, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b1, '{1'b0, MD_OFF,   1'b0}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b1, MD_ON,    1'b1}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b0, MD_FLASH, 1'b1}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b1, MD_SOS,   1'b1}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b1, MD_ON,    1'b1}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b0, MD_OFF,   1'b1}},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b1, 1'b0, NO_CHECK},
		'{ROW_TICK,  CFG_DEBOUNCE,   16'd0,     1'b0, 1'b1, '{1'b0, MD_OFF,   1'b0}}
	};

	function automatic logic [TB_TIMER_BITS-1:0] sat_bump(input logic [TB_TIMER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// one millisecond tick of the sequencer: timers, edge judgment, then LED pattern
	function automatic tick_result_t step_sequencer(input logic lvl);
		tick_result_t     r;
		logic [1:0]       next_mode;
		logic [CFG_W-1:0] span;
		r = '0;
		edge_age  = sat_bump(edge_age);
		press_age = sat_bump(press_age);
		if (lvl != lvl_prev) begin
			lvl_prev = lvl;
			if (edge_age >= db_cfg) begin
				edge_age = '0;
				if (lvl) begin
					press_age = '0;
				end else begin
					if (press_age >= lp_cfg) begin
						next_mode = MD_OFF;
					end else begin
						case (cur_mode)
							MD_OFF:   next_mode = MD_ON;
							MD_ON:    next_mode = MD_FLASH;
							MD_FLASH: next_mode = MD_SOS;
							default:  next_mode = MD_ON;
						endcase
					end
					if (next_mode != cur_mode) begin
						cur_mode    = next_mode;
						morse_phase = '0;
						phase_age   = '0;
						r.changed   = 1'b1;
					end
				end
			end
		end
		case (cur_mode)
			MD_FLASH: begin
				if (morse_phase > 5'd1)
					morse_phase = '0;
				r.led = morse_phase[0];
				span = morse_phase[0] ? fon_cfg : foff_cfg;
				phase_age = sat_bump(phase_age);
				if (phase_age >= span) begin
					phase_age   = '0;
					morse_phase = morse_phase ^ 5'd1;
				end
			end
			MD_SOS: begin
				if (morse_phase >= SOS_PHASES)
					morse_phase = '0;
				r.led = ~morse_phase[0];
				// dashes and the letter gaps are long, the word gap longest
				case (morse_phase)
					5'd5, 5'd6, 5'd8, 5'd10, 5'd11: span = SOS_DASH;
					5'd17:                          span = SOS_GAP;
					default:                        span = SOS_DOT;
				endcase
				phase_age = sat_bump(phase_age);
				if (phase_age >= span) begin
					phase_age   = '0;
					morse_phase = (morse_phase == SOS_PHASES - 1) ? '0 : morse_phase + 5'd1;
				end
			end
			default: begin
				r.led       = (cur_mode == MD_ON);
				morse_phase = '0;
				phase_age   = '0;
			end
		endcase
		r.mode = cur_mode;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at result %0d: %s", ticks_checked, what);
	endtask

	// offer one tick request, with random idle cycles ahead of it unless steady
	task automatic send_tick(input logic lvl, input logic known, input tick_result_t want);
		tick_result_t predicted;
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= lvl;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		predicted = step_sequencer(lvl);
		expected_ticks.push_back(known ? want : predicted);
		ticks_sent++;
	endtask

	// drain: every tick yields a result, so an empty queue means the pipe is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_DEBOUNCE:   db_cfg   = val;
			CFG_LONG_PRESS: lp_cfg   = val;
			CFG_FLASH_OFF:  foff_cfg = val;
			default:        fon_cfg  = val;
		endcase
	endtask

	// one press and release, mostly well formed, sometimes with chatter or plain noise
	task automatic press_cycle();
		int hold;
		int gap;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 8))
				send_tick(1'($urandom_range(1)), 1'b0, NO_CHECK);
			return;
		end
		case ($urandom_range(3))
			0:       hold = int'(db_cfg) + $urandom_range(0, 4);
			1:       hold = $urandom_range(1, 40);
			2:       hold = int'(lp_cfg) + $urandom_range(0, 2);
			default: hold = int'(lp_cfg) - 1;
		endcase
		if (hold > 60)
			hold = $urandom_range(1, 60);
		if (hold < 1)
			hold = 1;
		gap = ($urandom_range(5) == 0) ? $urandom_range(1, 3) : int'(db_cfg) + $urandom_range(0, 4);
		if (gap > 60)
			gap = 60;
		if (gap < 1)
			gap = 1;
		// contact chatter on the press
		if ($urandom_range(4) == 0) begin
			send_tick(1'b1, 1'b0, NO_CHECK);
			send_tick(1'b0, 1'b0, NO_CHECK);
		end
		repeat (hold)
			send_tick(1'b1, 1'b0, NO_CHECK);
		// a short drop out in the middle of the press
		if ($urandom_range(5) == 0) begin
			send_tick(1'b0, 1'b0, NO_CHECK);
			send_tick(1'b1, 1'b0, NO_CHECK);
		end
		repeat (gap)
			send_tick(1'b0, 1'b0, NO_CHECK);
	endtask

	// result side: random stall, plus one long hold-off to fill the pipe
	always @(posedge clk) begin
		if (!backpressure_done && ticks_checked >= 400) begin
			backpressure_done <= 1'b1;
			backpressure_left <= 60;
			out_stall         <= 1'b1;
		end else if (backpressure_left != 0) begin
			backpressure_left <= backpressure_left - 1;
			out_stall         <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 34);
		end
	end

	// compare each result request taken at the coming edge with the oldest prediction
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("result with no tick pending");
			end else begin
				head = expected_ticks.pop_front();
				if (led !== head.led)
					report_mismatch($sformatf("led %b, expected %b", led, head.led));
				if (mode !== head.mode)
					report_mismatch($sformatf("mode %0d, expected %0d", mode, head.mode));
				if (mode_changed !== head.changed)
					report_mismatch($sformatf("mode_changed %b, expected %b",
						mode_changed, head.changed));
			end
			ticks_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[button_mode_led_pattern_controller_core] ERROR");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_tick(dir_rows[i].level, dir_rows[i].known, dir_rows[i].want);
			end
		end

		// random press sequences under a sweep of register settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			write_reg(CFG_DEBOUNCE, (ph % 4 == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
			write_reg(CFG_LONG_PRESS, (ph == 1) ? 16'd0 :
				(ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 30)));
			write_reg(CFG_FLASH_OFF, (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 6)));
			write_reg(CFG_FLASH_ON, (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 6)));
			steady <= (ph == 4);
			target = ticks_sent + TICKS_PER_PH;
			while (ticks_sent < target)
				press_cycle();
		end

		// soak: step into SOS and run through its first phases
		wait_idle();
		steady <= 1'b0;
		write_reg(CFG_DEBOUNCE, 16'd0);
		write_reg(CFG_LONG_PRESS, 16'd100);
		while (cur_mode != MD_SOS) begin
			send_tick(1'b1, 1'b0, NO_CHECK);
			send_tick(1'b0, 1'b0, NO_CHECK);
		end
		wait_idle();
		write_reg(CFG_DEBOUNCE, 16'd8);
		write_reg(CFG_LONG_PRESS, 16'd20);
		repeat (400)
			send_tick(1'b0, 1'b0, NO_CHECK);
		// accepted press, then a drop out lost inside the debounce window
		send_tick(1'b1, 1'b0, NO_CHECK);
		send_tick(1'b0, 1'b0, NO_CHECK);
		send_tick(1'b1, 1'b0, NO_CHECK);
		repeat (30)
			send_tick(1'b1, 1'b0, NO_CHECK);
		// release after a long press turns the mode off
		repeat (5)
			send_tick(1'b0, 1'b0, NO_CHECK);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("[button_mode_led_pattern_controller_core] OK");
		else
			$display("[button_mode_led_pattern_controller_core] ERROR");
		$finish;
	end

endmodule
